// ===== hdl/fpa_pkg.sv =====
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int FRAME_BYTES_DEF = 65536;
  localparam int PAL_ENTRIES_DEF = 256;
  localparam int PADDR_W         = 5;

  // pixel formats
  localparam logic [3:0] FMT_NONE   = 4'd0;
  localparam logic [3:0] FMT_PAL2   = 4'd1;
  localparam logic [3:0] FMT_PAL4   = 4'd2;
  localparam logic [3:0] FMT_PAL16  = 4'd3;
  localparam logic [3:0] FMT_PAL256 = 4'd4;
  localparam logic [3:0] FMT_RGB332 = 4'd5;
  localparam logic [3:0] FMT_RGB555 = 4'd6;
  localparam logic [3:0] FMT_RGB565 = 4'd7;
  localparam logic [3:0] FMT_RGB888 = 4'd8;
  localparam logic [3:0] FMT_BGR888 = 4'd9;
  localparam logic [3:0] FMT_RGBA   = 4'd10;
  localparam logic [3:0] FMT_RGBX   = 4'd11;
  localparam logic [3:0] FMT_BGRA   = 4'd12;

  // request kinds
  localparam logic [2:0] REQ_RD_COL = 3'd0;
  localparam logic [2:0] REQ_RD_IDX = 3'd1;
  localparam logic [2:0] REQ_WR_COL = 3'd2;
  localparam logic [2:0] REQ_WR_IDX = 3'd3;
  localparam logic [2:0] REQ_PAL_WR = 3'd4;
  localparam logic [2:0] REQ_PAL_RD = 3'd5;

  // register indexes
  localparam logic [2:0] REG_FMT    = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_STRIDE = 3'd3;
  localparam logic [2:0] REG_FLIP   = 3'd4;
  localparam logic [2:0] REG_PCOUNT = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE, OP_RD_COL, OP_RD_IDX, OP_WR_COL, OP_WR_IDX, OP_PAL_WR, OP_PAL_RD
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_ADDR, ST_DISP, ST_RD, ST_RDW, ST_WR, ST_PRD, ST_PWR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic addr;
    logic rd;
    logic wr;
    logic prd;
    logic pwr;
    logic resp;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic ok;
    op_t  op;
    logic pal;
    logic last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/fpa_ctrl.sv =====
`timescale 1ns / 1ps
module fpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  fpa_pkg::sts_t sts,
  output fpa_pkg::cmd_t cmd
);
  import fpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr = 1'b1;
        state_next = ST_DISP;
      end
      ST_DISP: begin
        priority if (!sts.ok) state_next = ST_RESP;
        else if (sts.op == OP_WR_COL) state_next = ST_WR;
        else if (sts.op == OP_PAL_WR) state_next = ST_PWR;
        else if (sts.op == OP_PAL_RD) state_next = ST_PRD;
        else if (sts.op == OP_NONE) state_next = ST_RESP;
        else state_next = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        if (sts.last) state_next = ST_RDW;
      end
      ST_RDW: begin
        priority if (sts.op == OP_WR_IDX) state_next = ST_WR;
        else if (sts.op == OP_RD_COL && sts.pal) state_next = ST_PRD;
        else state_next = ST_RESP;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.last) state_next = ST_RESP;
      end
      ST_PRD: begin
        cmd.prd = 1'b1;
        state_next = ST_RESP;
      end
      ST_PWR: begin
        cmd.pwr = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/fpa_dp.sv =====
`timescale 1ns / 1ps
module fpa_dp #(
  parameter int FRAME_BYTES     = fpa_pkg::FRAME_BYTES_DEF,
  parameter int PALETTE_ENTRIES = fpa_pkg::PAL_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [63:0]                 s_tdata,
  input  logic [2:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,
  output logic [0:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  input  fpa_pkg::cmd_t               cmd,
  output fpa_pkg::sts_t               sts
);
  import fpa_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int PW = $clog2(PALETTE_ENTRIES);

  // configuration
  logic [3:0]  fmt;
  logic [12:0] img_w, img_h;
  logic [14:0] stride;
  logic        flip;
  logic [8:0]  pcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= '0; img_w <= '0; img_h <= '0; stride <= '0; flip <= 1'b0; pcount <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_FMT:    fmt <= pwdata[3:0];
        REG_WIDTH:  img_w <= pwdata[12:0];
        REG_HEIGHT: img_h <= pwdata[12:0];
        REG_STRIDE: stride <= pwdata[14:0];
        REG_FLIP:   flip <= pwdata[0];
        REG_PCOUNT: pcount <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FMT:    prdata = {28'd0, fmt};
      REG_WIDTH:  prdata = {19'd0, img_w};
      REG_HEIGHT: prdata = {19'd0, img_h};
      REG_STRIDE: prdata = {17'd0, stride};
      REG_FLIP:   prdata = {31'd0, flip};
      REG_PCOUNT: prdata = {23'd0, pcount};
      default:    prdata = '0;
    endcase
  end

  // request registers
  logic [2:0]  req;
  logic [11:0] px, py;
  logic [7:0]  ir, ig, ib, ia, iidx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= s_tuser;
      px <= s_tdata[11:0];
      py <= s_tdata[23:12];
      ir <= s_tdata[31:24];
      ig <= s_tdata[39:32];
      ib <= s_tdata[47:40];
      ia <= s_tdata[55:48];
      iidx <= s_tdata[63:56];
    end
  end

  // format decode
  logic       is_pal, has_fmt;
  logic [1:0] nbm1;
  logic [13:0] xoff;
  assign is_pal  = (fmt >= FMT_PAL2) && (fmt <= FMT_PAL256);
  assign has_fmt = (fmt >= FMT_PAL2) && (fmt <= FMT_BGRA);

  always_comb begin
    unique case (fmt)
      FMT_PAL2:   begin nbm1 = 2'd0; xoff = 14'(px >> 3); end
      FMT_PAL4:   begin nbm1 = 2'd0; xoff = 14'(px >> 2); end
      FMT_PAL16:  begin nbm1 = 2'd0; xoff = 14'(px >> 1); end
      FMT_PAL256, FMT_RGB332: begin nbm1 = 2'd0; xoff = 14'(px); end
      FMT_RGB555, FMT_RGB565: begin nbm1 = 2'd1; xoff = {1'b0, px, 1'b0}; end
      FMT_RGB888, FMT_BGR888: begin nbm1 = 2'd2; xoff = 14'(px) + {1'b0, px, 1'b0}; end
      FMT_RGBA, FMT_RGBX, FMT_BGRA: begin nbm1 = 2'd3; xoff = {px, 2'b00}; end
      default:    begin nbm1 = 2'd0; xoff = '0; end
    endcase
  end

  // address stages
  logic [12:0] row;
  logic [27:0] prod;
  logic [13:0] xoff_q;
  logic        coord_ok, pal_ok;
  logic [28:0] sum;
  logic [29:0] pend;
  logic        loc;

  assign row = flip ? (img_h - 13'd1 - {1'b0, py}) : {1'b0, py};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod     <= 28'(row) * 28'(stride);
      xoff_q   <= xoff;
      coord_ok <= ({1'b0, px} < img_w) && ({1'b0, py} < img_h);
      pal_ok   <= ({1'b0, iidx} < pcount) && (9'(iidx) < 9'(PALETTE_ENTRIES));
    end
  end

  assign sum  = 29'(prod) + 29'(xoff_q);
  assign pend = 30'(sum) + 30'(nbm1) + 30'd1;
  assign loc  = coord_ok && has_fmt && (pend <= 30'(FRAME_BYTES));

  logic          ok_q;
  op_t           op_q;
  logic [AW-1:0] addr_q;
  logic [1:0]    k;

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_q <= 1'b0;
      op_q <= OP_NONE;
    end else if (cmd.addr) begin
      addr_q <= sum[AW-1:0];
      unique case (req)
        REQ_RD_COL: begin op_q <= OP_RD_COL; ok_q <= loc; end
        REQ_RD_IDX: begin op_q <= OP_RD_IDX; ok_q <= loc && is_pal; end
        REQ_WR_COL: begin op_q <= OP_WR_COL; ok_q <= loc && !is_pal; end
        REQ_WR_IDX: begin op_q <= OP_WR_IDX; ok_q <= loc && is_pal; end
        REQ_PAL_WR: begin op_q <= OP_PAL_WR; ok_q <= pal_ok; end
        REQ_PAL_RD: begin op_q <= OP_PAL_RD; ok_q <= pal_ok; end
        default:    begin op_q <= OP_NONE; ok_q <= 1'b0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.addr) begin
      k <= '0;
    end else if ((cmd.rd || cmd.wr) && (k != nbm1)) begin
      k <= k + 2'd1;
    end
  end

  // clearing pass
  logic [AW-1:0] clr_cnt;
  logic          clr_last;
  assign clr_last = (clr_cnt == AW'(FRAME_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr && !clr_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // byte capture
  logic [7:0] rdata;
  logic       rd_pend;
  logic [1:0] rd_k;
  logic [7:0] sb [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= k;
    if (rd_pend) sb[rd_k] <= rdata;
  end

  // packed index
  logic [2:0] sh;
  logic [7:0] msk, msk_sh, pix_idx, merged;

  always_comb begin
    unique case (fmt)
      FMT_PAL2:  begin sh = 3'd7 - px[2:0];     msk = 8'h01; end
      FMT_PAL4:  begin sh = {~px[1:0], 1'b0};  msk = 8'h03; end
      FMT_PAL16: begin sh = {~px[0], 2'b00};   msk = 8'h0F; end
      default:   begin sh = 3'd0;              msk = 8'hFF; end
    endcase
  end

  assign msk_sh  = msk << sh;
  assign pix_idx = (sb[0] >> sh) & msk;
  assign merged  = (sb[0] & ~msk_sh) | ((iidx << sh) & msk_sh);

  // bytes to write
  logic [7:0] wb [4];

  always_comb begin
    wb[0] = ir; wb[1] = ig; wb[2] = ib; wb[3] = ia;
    unique case (fmt)
      FMT_RGB332: wb[0] = {ir[7:5], ig[7:5], ib[7:6]};
      FMT_RGB555: begin
        wb[0] = {1'b0, ir[7:3], ig[7:6]};
        wb[1] = {ig[5:3], ib[7:3]};
      end
      FMT_RGB565: begin
        wb[0] = {ir[7:3], ig[7:5]};
        wb[1] = {ig[4:2], ib[7:3]};
      end
      FMT_BGR888, FMT_BGRA: begin
        wb[0] = ib; wb[2] = ir;
      end
      default: ;
    endcase
  end

  // frame memory
  logic [7:0]    fmem [FRAME_BYTES];
  logic [AW-1:0] facc;
  logic          fwe;
  logic [AW-1:0] fwa;
  logic [7:0]    fwd;

  assign facc = addr_q + AW'(k);
  assign fwe  = cmd.clr || cmd.wr;
  assign fwa  = cmd.clr ? clr_cnt : facc;
  assign fwd  = cmd.clr ? 8'd0 : ((op_q == OP_WR_IDX) ? merged : wb[k]);

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= fwd;
    rdata <= fmem[facc];
  end

  // palette memory
  logic [23:0]   pmem [PALETTE_ENTRIES];
  logic [23:0]   pq;
  logic          pal_hit;
  logic          pwe;
  logic [PW-1:0] pwa, pra;
  logic [23:0]   pwd;

  assign pwe = (cmd.clr && ({1'b0, clr_cnt} < (AW + 1)'(PALETTE_ENTRIES))) || cmd.pwr;
  assign pwa = cmd.clr ? clr_cnt[PW-1:0] : iidx[PW-1:0];
  assign pwd = cmd.clr ? 24'h808080 : {ir, ig, ib};
  assign pra = (op_q == OP_PAL_RD) ? iidx[PW-1:0] : pix_idx[PW-1:0];

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    if (cmd.prd) begin
      pq <= pmem[pra];
      pal_hit <= (op_q == OP_PAL_RD) || (9'(pix_idx) < 9'(PALETTE_ENTRIES));
    end
  end

  // result
  logic [7:0] rr, rg, rb, ra, ri;

  always_comb begin
    rr = '0; rg = '0; rb = '0; ra = '0; ri = '0;
    if (ok_q) begin
      unique case (op_q)
        OP_RD_COL: begin
          ra = 8'hFF;
          if (is_pal) begin
            if (pal_hit) {rr, rg, rb} = pq;
          end else begin
            unique case (fmt)
              FMT_RGB332: begin
                rr = {sb[0][7:5], 5'd0}; rg = {sb[0][4:2], 5'd0}; rb = {sb[0][1:0], 6'd0};
              end
              FMT_RGB555: begin
                rr = {sb[0][6:2], 3'd0};
                rg = {sb[0][1:0], sb[1][7:5], 3'd0};
                rb = {sb[1][4:0], 3'd0};
              end
              FMT_RGB565: begin
                rr = {sb[0][7:3], 3'd0};
                rg = {sb[0][2:0], sb[1][7:5], 2'd0};
                rb = {sb[1][4:0], 3'd0};
              end
              FMT_RGBA: begin rr = sb[0]; rg = sb[1]; rb = sb[2]; ra = sb[3]; end
              FMT_BGR888: begin rb = sb[0]; rg = sb[1]; rr = sb[2]; end
              FMT_BGRA: begin rb = sb[0]; rg = sb[1]; rr = sb[2]; ra = sb[3]; end
              default: begin rr = sb[0]; rg = sb[1]; rb = sb[2]; end
            endcase
          end
        end
        OP_RD_IDX: ri = pix_idx;
        OP_PAL_RD: begin {rr, rg, rb} = pq; ra = 8'hFF; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.resp) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      m_tdata <= {ri, ra, rb, rg, rr};
      m_tuser <= ok_q;
    end
  end

  assign sts.ok       = ok_q;
  assign sts.op       = op_q;
  assign sts.pal      = is_pal;
  assign sts.last     = (k == nbm1);
  assign sts.clr_last = clr_last;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

// ===== hdl/framebuffer_pixel_access_core.sv =====
`timescale 1ns / 1ps
// Pixel access to a byte-wide frame store and a 256-entry palette. Each request
// passes through set-up steps (capture, row multiply, address add and range check,
// dispatch, result), plus a step per pixel byte read or written (up to four), a
// wait step after reads, and a step for a palette access. After reset the frame
// store is cleared byte by byte before requests are taken.
module framebuffer_pixel_access_core #(
  parameter int FRAME_BYTES     = fpa_pkg::FRAME_BYTES_DEF,
  parameter int PALETTE_ENTRIES = fpa_pkg::PAL_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,  // pos_x, pos_y, in_red, in_green, in_blue, in_alpha, in_index
  input  logic [2:0]                  s_tuser,  // req_type
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,  // out_red, out_green, out_blue, out_alpha, out_index
  output logic [0:0]                  m_tuser,  // ok
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpa_dp #(
    .FRAME_BYTES     (FRAME_BYTES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import fpa_pkg::*;

  localparam int FB = 65536;
  localparam int PE = 256;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic [2:0] req;
    logic [11:0] x, y;
    logic [7:0] r, g, b, a, idx;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] r, g, b, a, idx;
    logic ok;
  } pix_res_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic s_tready, m_tvalid, pready;
  logic [63:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic [39:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  framebuffer_pixel_access_core dut (.*);

  logic [7:0] fb_mem [FB];
  logic [23:0] pal_mem [PE];
  logic [3:0] c_fmt;
  logic [12:0] c_w, c_h;
  logic [14:0] c_stride;
  logic c_flip;
  logic [8:0] c_pcount;

  pix_res_t pending_res[$];
  int errors = 0;
  longint cyc = 0;
  int send_idle = 0, recv_stall = 0;

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("framebuffer_pixel_access_core test failed");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic int fmt_bpp(logic [3:0] f);
    case (f)
      FMT_PAL2: return 1;
      FMT_PAL4: return 2;
      FMT_PAL16: return 4;
      FMT_PAL256, FMT_RGB332: return 8;
      FMT_RGB555, FMT_RGB565: return 16;
      FMT_RGB888, FMT_BGR888: return 24;
      FMT_RGBA, FMT_RGBX, FMT_BGRA: return 32;
      default: return 0;
    endcase
  endfunction

  function automatic pix_res_t predict_pixel(pix_req_t q);
    pix_res_t o;
    int bpp, sh, per, pi;
    longint row, ad;
    logic pal, hit;
    logic [7:0] m;
    o = '{default: '0};
    bpp = fmt_bpp(c_fmt);
    pal = c_fmt >= FMT_PAL2 && c_fmt <= FMT_PAL256;
    hit = 0;
    ad = 0;
    sh = 0;
    if (bpp != 0 && q.x < c_w && q.y < c_h) begin
      row = c_flip ? longint'(c_h) - 1 - q.y : q.y;
      ad = row * c_stride + (longint'(q.x) * bpp) / 8;
      hit = ad + (bpp + 7) / 8 <= FB;
      if (bpp < 8) begin
        per = 8 / bpp;
        sh = (per - 1 - (q.x % per)) * bpp;
      end
    end
    m = 8'((1 << bpp) - 1);
    case (q.req)
      REQ_RD_COL: if (hit) begin
        o.ok = 1'b1; o.a = 8'd255;
        if (pal) begin
          pi = (fb_mem[ad] >> sh) & m;
          {o.r, o.g, o.b} = pal_mem[pi];
        end else case (c_fmt)
          FMT_RGB332: begin
            o.r = fb_mem[ad] & 8'hE0; o.g = (fb_mem[ad] & 8'h1C) << 3;
            o.b = (fb_mem[ad] & 8'h03) << 6;
          end
          FMT_RGB555: begin
            o.r = (fb_mem[ad] & 8'h7C) << 1;
            o.g = ((fb_mem[ad] & 8'h03) << 6) | ((fb_mem[ad+1] & 8'hE0) >> 2);
            o.b = (fb_mem[ad+1] & 8'h1F) << 3;
          end
          FMT_RGB565: begin
            o.r = fb_mem[ad] & 8'hF8;
            o.g = ((fb_mem[ad] & 8'h07) << 5) | ((fb_mem[ad+1] & 8'hE0) >> 3);
            o.b = (fb_mem[ad+1] & 8'h1F) << 3;
          end
          FMT_RGB888, FMT_RGBX: begin
            o.r = fb_mem[ad]; o.g = fb_mem[ad+1]; o.b = fb_mem[ad+2];
          end
          FMT_RGBA: begin
            o.r = fb_mem[ad]; o.g = fb_mem[ad+1]; o.b = fb_mem[ad+2]; o.a = fb_mem[ad+3];
          end
          FMT_BGR888: begin
            o.b = fb_mem[ad]; o.g = fb_mem[ad+1]; o.r = fb_mem[ad+2];
          end
          default: begin
            o.b = fb_mem[ad]; o.g = fb_mem[ad+1]; o.r = fb_mem[ad+2]; o.a = fb_mem[ad+3];
          end
        endcase
      end
      REQ_RD_IDX: if (hit && pal) begin
        o.idx = (fb_mem[ad] >> sh) & m;
        o.ok = 1'b1;
      end
      REQ_WR_COL: if (hit && !pal) begin
        o.ok = 1'b1;
        case (c_fmt)
          FMT_RGB332: fb_mem[ad] = (q.r & 8'hE0) | ((q.g & 8'hE0) >> 3) | (q.b >> 6);
          FMT_RGB555: begin
            fb_mem[ad] = ((q.r & 8'hF8) >> 1) | (q.g >> 6);
            fb_mem[ad+1] = ((q.g & 8'h38) << 2) | (q.b >> 3);
          end
          FMT_RGB565: begin
            fb_mem[ad] = (q.r & 8'hF8) | (q.g >> 5);
            fb_mem[ad+1] = ((q.g & 8'h1C) << 3) | (q.b >> 3);
          end
          FMT_RGB888: begin fb_mem[ad] = q.r; fb_mem[ad+1] = q.g; fb_mem[ad+2] = q.b; end
          FMT_BGR888: begin fb_mem[ad] = q.b; fb_mem[ad+1] = q.g; fb_mem[ad+2] = q.r; end
          FMT_RGBA, FMT_RGBX: begin
            fb_mem[ad] = q.r; fb_mem[ad+1] = q.g; fb_mem[ad+2] = q.b; fb_mem[ad+3] = q.a;
          end
          default: begin
            fb_mem[ad] = q.b; fb_mem[ad+1] = q.g; fb_mem[ad+2] = q.r; fb_mem[ad+3] = q.a;
          end
        endcase
      end
      REQ_WR_IDX: if (hit && pal) begin
        fb_mem[ad] = (fb_mem[ad] & ~(m << sh)) | ((q.idx << sh) & (m << sh));
        o.ok = 1'b1;
      end
      REQ_PAL_WR: if (q.idx < c_pcount) begin
        pal_mem[q.idx] = {q.r, q.g, q.b};
        o.ok = 1'b1;
      end
      REQ_PAL_RD: if (q.idx < c_pcount) begin
        {o.r, o.g, o.b} = pal_mem[q.idx];
        o.a = 8'd255;
        o.ok = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic reg_write(logic [2:0] ri, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= PADDR_W'(ri) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (ri)
      REG_FMT: c_fmt = v[3:0];
      REG_WIDTH: c_w = v[12:0];
      REG_HEIGHT: c_h = v[12:0];
      REG_STRIDE: c_stride = v[14:0];
      REG_FLIP: c_flip = v[0];
      default: c_pcount = v[8:0];
    endcase
  endtask

  task automatic set_layout(logic [3:0] f, int w, int h, int st, bit fl, int pc);
    reg_write(REG_FMT, 32'(f));
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    reg_write(REG_STRIDE, 32'(st));
    reg_write(REG_FLIP, 32'(fl));
    reg_write(REG_PCOUNT, 32'(pc));
  endtask

  task automatic send_request(pix_req_t q);
    @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    s_tvalid <= 1;
    s_tuser <= q.req;
    s_tdata <= {q.idx, q.a, q.b, q.g, q.r, q.y, q.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_res.push_back(predict_pixel(q));
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  task automatic drain;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(negedge clk)
    m_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

  always @(posedge clk) begin
    pix_res_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) report("unexpected result", m_tdata[31:0], 32'd0);
      else begin
        w = pending_res.pop_front();
        if (m_tdata[7:0] !== w.r) report("red", 32'(m_tdata[7:0]), 32'(w.r));
        if (m_tdata[15:8] !== w.g) report("green", 32'(m_tdata[15:8]), 32'(w.g));
        if (m_tdata[23:16] !== w.b) report("blue", 32'(m_tdata[23:16]), 32'(w.b));
        if (m_tdata[31:24] !== w.a) report("alpha", 32'(m_tdata[31:24]), 32'(w.a));
        if (m_tdata[39:32] !== w.idx) report("index", 32'(m_tdata[39:32]), 32'(w.idx));
        if (m_tuser[0] !== w.ok) report("ok", 32'(m_tuser[0]), 32'(w.ok));
      end
    end
  end

  function automatic pix_req_t mk(logic [2:0] rq, int x, int y, logic [7:0] r, g, b, a, i);
    pix_req_t q;
    q.req = rq; q.x = 12'(x); q.y = 12'(y); q.r = r; q.g = g; q.b = b; q.a = a; q.idx = i;
    return q;
  endfunction

  function automatic pix_req_t rand_req(bit noise);
    pix_req_t q;
    q.req = noise ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    q.x = noise ? 12'($urandom) : 12'($urandom_range(c_w + 1));
    q.y = noise ? 12'($urandom) : 12'($urandom_range(c_h));
    q.r = 8'($urandom); q.g = 8'($urandom); q.b = 8'($urandom); q.a = 8'($urandom);
    q.idx = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(c_pcount));
    return q;
  endfunction

  typedef struct {
    pix_req_t q;
    bit known;
    pix_res_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    pix_res_t got;
    logic [3:0] fmts[13];
    int phase;
    for (int i = 0; i < FB; i++) fb_mem[i] = '0;
    for (int i = 0; i < PE; i++) pal_mem[i] = 24'h808080;
    c_fmt = '0; c_w = '0; c_h = '0; c_stride = '0; c_flip = 1'b0; c_pcount = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // after reset everything is rejected; then extremes and errors, then a small image
    rows.push_back('{mk(REQ_RD_COL, 0, 0, 0, 0, 0, 0, 0), 1, '{default: 0}});
    rows.push_back('{mk(REQ_PAL_RD, 0, 0, 0, 0, 0, 0, 0), 1, '{default: 0}});
    foreach (rows[i]) send_request(rows[i].q);
    drain();

    set_layout(FMT_RGBA, 4096, 4096, 16384, 1, 256);
    rows.delete();
    rows.push_back('{mk(REQ_WR_COL, 4095, 4095, 255, 255, 255, 255, 255), 0, '{default: 0}});
    rows.push_back('{mk(REQ_RD_COL, 4095, 4095, 0, 0, 0, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(REQ_WR_COL, 3, 0, 1, 2, 3, 4, 0), 0, '{default: 0}});
    rows.push_back('{mk(REQ_RD_COL, 3, 0, 0, 0, 0, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(REQ_RD_IDX, 1, 1, 0, 0, 0, 0, 0), 1, '{default: 0}});
    rows.push_back('{mk(3'd6, 1, 1, 0, 0, 0, 0, 0), 1, '{default: 0}});
    rows.push_back('{mk(3'd7, 1, 1, 0, 0, 0, 0, 0), 1, '{default: 0}});
    rows.push_back('{mk(REQ_PAL_WR, 0, 0, 8'h12, 8'h34, 8'h56, 0, 255), 0, '{default: 0}});
    rows.push_back('{mk(REQ_PAL_RD, 0, 0, 0, 0, 0, 0, 255), 0, '{default: 0}});
    rows.push_back('{mk(REQ_PAL_RD, 0, 0, 0, 0, 0, 0, 7), 1,
                     '{8'h80, 8'h80, 8'h80, 8'hFF, 8'h0, 1'b1}});
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = predict_pixel(rows[i].q);
        if (got != rows[i].want) report("table row", 32'(i), 32'd0);
      end
      send_request(rows[i].q);
    end
    drain();

    set_layout(FMT_PAL2, 8, 4, 1, 0, 2);
    rows.delete();
    rows.push_back('{mk(REQ_WR_IDX, 0, 0, 0, 0, 0, 0, 8'hFF), 0, '{default: 0}});
    rows.push_back('{mk(REQ_RD_IDX, 0, 0, 0, 0, 0, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(REQ_RD_COL, 0, 0, 0, 0, 0, 0, 0), 0, '{default: 0}});
    rows.push_back('{mk(REQ_WR_COL, 0, 0, 1, 1, 1, 1, 0), 1, '{default: 0}});
    rows.push_back('{mk(REQ_RD_COL, 8, 0, 0, 0, 0, 0, 0), 1, '{default: 0}});
    rows.push_back('{mk(REQ_PAL_WR, 0, 0, 1, 1, 1, 0, 2), 1, '{default: 0}});
    foreach (rows[i]) send_request(rows[i].q);
    drain();

    fmts = '{FMT_PAL2, FMT_PAL4, FMT_PAL16, FMT_PAL256, FMT_RGB332, FMT_RGB555,
             FMT_RGB565, FMT_RGB888, FMT_BGR888, FMT_RGBA, FMT_RGBX, FMT_BGRA, 4'd14};
    for (int k = 0; k < 30; k++) begin
      phase = k % 4;
      send_idle = (phase == 1 || phase == 3) ? (phase == 3 ? 26 : 60) : 0;
      recv_stall = (phase == 2 || phase == 3) ? (phase == 3 ? 26 : 60) : 0;
      if (k % 7 == 6)
        set_layout(fmts[$urandom_range(12)], $urandom_range(4096), $urandom_range(4096),
                   $urandom_range(16384), $urandom_range(1), $urandom_range(256));
      else
        set_layout(fmts[k % 13], $urandom_range(1, 40), $urandom_range(1, 40),
                   $urandom_range(0, 200), $urandom_range(1), $urandom_range(256));
      for (int n = 0; n < 15; n++) send_request(rand_req($urandom_range(9) == 0));
      drain();
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (errors == 0) $display("framebuffer_pixel_access_core test passed");
    else $display("framebuffer_pixel_access_core test failed");
    $finish;
  end
endmodule

// ===== framebuffer_pixel_access_core.f =====
hdl/fpa_pkg.sv
hdl/fpa_ctrl.sv
hdl/fpa_dp.sv
hdl/framebuffer_pixel_access_core.sv
dv/tb.sv
